@@ rtl/b64c_pkg.sv @@
// ----------------------------------------------------------------------------
// Base64 codec package
// Shared types, constants and character mapping functions.
// ----------------------------------------------------------------------------
package b64c_pkg;

  localparam int unsigned QUEUE_AW = 2;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // One group of results handed from the front to the back.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      last_idx;
    logic            last;
    logic            no_data;
  } job_t;

  function automatic logic [7:0] char_of(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'd97 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'd48 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c;
  endfunction

  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [5:0] v;
    if (c >= 8'd65 && c <= 8'd90) begin
      v = 6'(c - 8'd65);
    end else if (c >= 8'd97 && c <= 8'd122) begin
      v = 6'(c - 8'd97 + 8'd26);
    end else if (c >= 8'd48 && c <= 8'd57) begin
      v = 6'(c - 8'd48 + 8'd52);
    end else if (c == 8'd43) begin
      v = 6'd62;
    end else if (c == 8'd47) begin
      v = 6'd63;
    end else begin
      v = 6'd0;
    end
    return v;
  endfunction

endpackage

@@ rtl/b64c_front.sv @@
// ----------------------------------------------------------------------------
// Base64 codec front end
// Holds the mode and the partial group, and turns each finished group into
// one job for the back end.
// ----------------------------------------------------------------------------
module b64c_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wen,
  input  logic            cfg_wdata,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  input  logic            full,
  output logic            push,
  output b64c_pkg::job_t  push_job
);
  import b64c_pkg::*;

  logic        mode;
  logic [17:0] group_bits;
  logic [1:0]  group_count;
  logic [17:0] group_bits_next;
  logic [1:0]  group_count_next;
  logic [2:0]  n;
  logic [23:0] t;
  logic        has_result;
  logic        accept;
  job_t        job;

  assign in_ready = !full;
  assign accept   = in_valid && !full;
  assign push     = accept && has_result;
  assign push_job = job;
  assign n        = {1'b0, group_count} + 3'd1;

  always_comb begin
    job              = '0;
    has_result       = 1'b0;
    group_bits_next  = '0;
    group_count_next = '0;
    if (mode == MODE_ENCODE) begin
      t = {group_bits[15:0], in_byte};
      if (n == 3'd3) begin
        job.data[0]  = char_of(t[23:18]);
        job.data[1]  = char_of(t[17:12]);
        job.data[2]  = char_of(t[11:6]);
        job.data[3]  = char_of(t[5:0]);
        job.last_idx = 2'd3;
        job.last     = in_last;
        has_result   = 1'b1;
      end else if (in_last) begin
        has_result = 1'b1;
        job.last   = 1'b1;
        if (n == 3'd1) begin
          job.data[0]  = char_of(t[7:2]);
          job.data[1]  = char_of({t[1:0], 4'b0000});
          job.last_idx = 2'd1;
        end else begin
          job.data[0]  = char_of(t[15:10]);
          job.data[1]  = char_of(t[9:4]);
          job.data[2]  = char_of({t[3:0], 2'b00});
          job.last_idx = 2'd2;
        end
      end else begin
        group_bits_next  = {2'b00, t[15:0]};
        group_count_next = n[1:0];
      end
    end else begin
      t = {group_bits, sextet_of(in_byte)};
      if (n == 3'd4) begin
        job.data[0]  = t[23:16];
        job.data[1]  = t[15:8];
        job.data[2]  = t[7:0];
        job.last_idx = 2'd2;
        job.last     = in_last;
        has_result   = 1'b1;
      end else if (in_last) begin
        has_result = 1'b1;
        job.last   = 1'b1;
        if (n == 3'd1) begin
          job.no_data = 1'b1;
        end else if (n == 3'd2) begin
          job.data[0] = t[11:4];
        end else begin
          job.data[0]  = t[17:10];
          job.data[1]  = t[9:2];
          job.last_idx = 2'd1;
        end
      end else begin
        group_bits_next  = t[17:0];
        group_count_next = n[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_ENCODE;
      group_bits  <= '0;
      group_count <= '0;
    end else if (cfg_wen) begin
      mode        <= cfg_wdata;
      group_bits  <= '0;
      group_count <= '0;
    end else if (accept) begin
      group_bits  <= group_bits_next;
      group_count <= group_count_next;
    end
  end

endmodule

@@ rtl/b64c_queue.sv @@
// ----------------------------------------------------------------------------
// Base64 codec job queue
// Small first-in first-out buffer of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module b64c_queue #(
  parameter int unsigned AW = b64c_pkg::QUEUE_AW
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  b64c_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output b64c_pkg::job_t  pop_job,
  output logic            empty
);
  import b64c_pkg::*;

  localparam int unsigned DEPTH = 1 << AW;

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/b64c_back.sv @@
// ----------------------------------------------------------------------------
// Base64 codec back end
// Unpacks each job into single results behind a registered output stage.
// ----------------------------------------------------------------------------
module b64c_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  b64c_pkg::job_t  head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            no_data
);
  import b64c_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       load;
  logic       advance;
  logic       fin;

  assign load    = !out_valid || out_ready;
  assign advance = cur_valid && load;
  assign fin     = advance && (idx == cur.last_idx);
  assign pop     = !empty && (!cur_valid || fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= cur_valid;
      end
      if (advance) begin
        idx <= idx + 1'b1;
      end
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (fin) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (advance) begin
      out_byte <= cur.data[idx];
      out_last <= cur.last && (idx == cur.last_idx);
      no_data  <= cur.no_data;
    end
  end

endmodule

@@ rtl/base64_stream_codec_unpadded.sv @@
// ----------------------------------------------------------------------------
// Base64 stream codec, unpadded
// Encodes bytes to Base64 characters or decodes characters to bytes.
//
// The s_axis channel takes one byte per transfer, with tlast marking the
// end of a message. The m_axis channel gives one character or byte per
// transfer; tlast marks the final result of a message and tuser marks a
// result that only carries the end mark (decode of a lone final character).
// The cfg_wen/cfg_wdata port writes the mode (0 encode, 1 decode) and drops
// any partial group; the user must write it only while the codec is idle,
// which the codec does not enforce. A group's first result passes through the
// job queue, the back end's job register and the output register to m_axis.
// The output stage gives one result per cycle while m_axis_tready is high, so
// decoding takes one byte every cycle, encoding three bytes per four results;
// the job queue absorbs the difference in bursts. Reset clears the mode to
// encode, the partial group, the queue and the output stage. If the receiver
// stalls, the output holds, the queue fills and s_axis_tready drops when full.
// ----------------------------------------------------------------------------
module base64_stream_codec_unpadded #(
  parameter int unsigned QUEUE_AW = b64c_pkg::QUEUE_AW
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic       cfg_wdata,      // mode
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_byte
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte
  output logic       m_axis_tlast,   // out_last
  output logic       m_axis_tuser    // no_data
);
  import b64c_pkg::*;

  job_t push_job;
  job_t head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  b64c_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .full      (full),
    .push      (push),
    .push_job  (push_job)
  );

  b64c_queue #(
    .AW (QUEUE_AW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (head),
    .empty    (empty)
  );

  b64c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .no_data   (m_axis_tuser)
  );

endmodule
